>>> sv/pmrs_pkg.sv
// Shared types and constants for the pointer motion rotate/scale unit.
// No dependencies; imported by every module of the block.
package pmrs_pkg;

  localparam int TYPE_W  = 16;
  localparam int CODE_W  = 16;
  localparam int VALUE_W = 32;
  localparam int FACT_W  = 16;
  localparam int DATA_W  = TYPE_W + CODE_W + VALUE_W;

  // serial multiplier: 32-bit signed multiplicand, 16-bit multiplier, one bit per cycle
  localparam int CAND_W  = 32;
  localparam int MPLR_W  = 16;
  localparam int HI_W    = CAND_W + 2;
  localparam int PROD_W  = 48;

  // remainder arithmetic, Q22
  localparam int FRAC_BITS = 22;
  localparam int REM_W     = FRAC_BITS + 1;
  localparam int IP_W      = PROD_W - FRAC_BITS;

  localparam logic [TYPE_W-1:0] EVT_REL = 16'd2;
  localparam logic [CODE_W-1:0] CODE_X  = 16'd0;
  localparam logic [CODE_W-1:0] CODE_Y  = 16'd1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

  localparam logic [FACT_W-1:0] COS_RESET   = 16'd16384;
  localparam logic [FACT_W-1:0] SIN_RESET   = 16'd0;
  localparam logic [FACT_W-1:0] SCALE_RESET = 16'd256;

  typedef struct packed {
    logic start;
    logic sgn;    // multiplier is two's complement: last bit weighs negative
  } mul_ctrl_t;

endpackage

>>> sv/pmrs_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pmrs_pkg.
module pmrs_serial_mul import pmrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mul_ctrl_t                ctrl,
  input  logic signed [CAND_W-1:0] cand,
  input  logic        [MPLR_W-1:0] mplr,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  logic                       busy_r;
  logic                       done_r;
  logic [$clog2(MPLR_W)-1:0]  cnt_r;
  logic                       sgn_r;
  logic signed [CAND_W-1:0]   cand_r;
  logic signed [HI_W-1:0]     hi_r;
  logic        [MPLR_W-1:0]   lo_r;

  logic                       last;
  logic signed [HI_W-1:0]     cand_ext;
  logic signed [HI_W-1:0]     addend;
  logic signed [HI_W-1:0]     hi_sum;

  always_comb begin
    last     = (cnt_r == ($clog2(MPLR_W))'(MPLR_W - 1));
    cand_ext = {{(HI_W - CAND_W){cand_r[CAND_W-1]}}, cand_r};
    if (!lo_r[0]) begin
      addend = '0;
    end else if (sgn_r && last) begin
      addend = -cand_ext;
    end else begin
      addend = cand_ext;
    end
    hi_sum = hi_r + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial product register shifts right as each multiplier bit retires
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sgn_r  <= ctrl.sgn;
      cand_r <= cand;
      hi_r   <= '0;
      lo_r   <= mplr;
    end else if (busy_r) begin
      hi_r <= {hi_sum[HI_W-1], hi_sum[HI_W-1:1]};
      lo_r <= {hi_sum[0], lo_r[MPLR_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r[PROD_W-MPLR_W-1:0], lo_r};

endmodule

>>> sv/pmrs_remainder.sv
// Per-axis sub-pixel accumulator: adds the Q22 product to the stored
// remainder and splits the sum toward zero. Depends on pmrs_pkg.
module pmrs_remainder import pmrs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [PROD_W-1:0]  prod,
  output logic                      done,
  output logic signed [VALUE_W-1:0] ival
);

  typedef enum logic [1:0] {
    R_IDLE,
    R_ABS,
    R_FIN
  } rstate_t;

  rstate_t                   state_r;
  logic                      done_r;
  logic signed [REM_W-1:0]   rem_r;
  logic signed [VALUE_W-1:0] ival_r;
  logic signed [PROD_W-1:0]  sum_r;
  logic                      neg_r;
  logic        [PROD_W-1:0]  mag_r;

  logic [IP_W-1:0]      ip;
  logic [FRAC_BITS-1:0] frac;

  assign ip   = mag_r[PROD_W-1:FRAC_BITS];
  assign frac = mag_r[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
      rem_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        R_IDLE: begin
          if (start) begin
            sum_r   <= prod + {{(PROD_W - REM_W){rem_r[REM_W-1]}}, rem_r};
            state_r <= R_ABS;
          end
        end
        R_ABS: begin
          neg_r   <= sum_r[PROD_W-1];
          mag_r   <= sum_r[PROD_W-1] ? PROD_W'(-sum_r) : PROD_W'(sum_r);
          state_r <= R_FIN;
        end
        R_FIN: begin
          // fraction keeps the sign of the sum
          rem_r   <= neg_r ? -$signed({1'b0, frac}) : $signed({1'b0, frac});
          ival_r  <= neg_r ? -$signed({{(VALUE_W - IP_W){1'b0}}, ip})
                           : $signed({{(VALUE_W - IP_W){1'b0}}, ip});
          done_r  <= 1'b1;
          state_r <= R_IDLE;
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign ival = ival_r;

endmodule

>>> sv/pointer_motion_rotate_scale_unit.sv
// Top level of the pointer motion rotate/scale unit.
// Depends on pmrs_pkg, pmrs_serial_mul and pmrs_remainder.

// One event at a time. A relative X or Y motion event passes from acceptance
// through the bit-serial rotation multiply, the load of the scale multiply,
// the bit-serial scale multiply (one multiplier bit per cycle in each), the
// remainder add and truncation, the pick of the results and the load of the
// output register; when both axes yield a result, the Y result follows the X
// result. A motion event that moves less than a pixel on both axes yields no
// result. Any other event passes through unchanged, held until the output
// register is free. A new event is accepted once the previous one has placed
// its last result into the output register, which may still be waiting on
// out_tready. Configuration writes are always taken.
module pointer_motion_rotate_scale_unit import pmrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // event_type, event_code, event_value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // out_type, out_code, out_value
  output logic                 out_tlast,  // is_last
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FACT_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_EMIT_X,
    S_EMIT_Y
  } state_t;

  function automatic logic signed [FACT_W-1:0] sat16(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-FACT_W:0] top;
    top = v[VALUE_W-1:FACT_W-1];
    if (!v[VALUE_W-1]) begin
      sat16 = (top == '0) ? v[FACT_W-1:0] : {1'b0, {(FACT_W - 1){1'b1}}};
    end else begin
      sat16 = (top == '1) ? v[FACT_W-1:0] : {1'b1, {(FACT_W - 1){1'b0}}};
    end
  endfunction

  // configuration
  logic [FACT_W-1:0] cos_r, sin_r, scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= COS_RESET;
      sin_r   <= SIN_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COS:   cos_r   <= cfg_data;
        CFG_SIN:   sin_r   <= cfg_data;
        CFG_SCALE: scale_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // input fields
  logic [TYPE_W-1:0]         in_type;
  logic [CODE_W-1:0]         in_code;
  logic signed [VALUE_W-1:0] in_value;
  logic                      in_accept;
  logic                      in_motion;

  assign in_type   = in_tdata[TYPE_W-1:0];
  assign in_code   = in_tdata[TYPE_W+CODE_W-1:TYPE_W];
  assign in_value  = in_tdata[DATA_W-1:TYPE_W+CODE_W];
  assign in_accept = in_tvalid && in_tready;
  assign in_motion = (in_type == EVT_REL) && ((in_code == CODE_X) || (in_code == CODE_Y));

  // rotation operands; Y motion takes x' = (-delta) * sin, which needs 17 bits
  logic signed [FACT_W-1:0] delta;
  logic signed [FACT_W:0]   delta_ext;
  logic signed [FACT_W:0]   cand_x17;
  logic                     code_is_x;

  always_comb begin
    delta     = sat16(in_value);
    delta_ext = {delta[FACT_W-1], delta};
    code_is_x = (in_code == CODE_X);
    cand_x17  = code_is_x ? delta_ext : -delta_ext;
  end

  state_t state_r, state_nxt;

  mul_ctrl_t                 mul_ctrl;
  logic signed [CAND_W-1:0]  cand_x, cand_y;
  logic        [MPLR_W-1:0]  mplr_x, mplr_y;
  logic                      mul_done, mul_done_y;
  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic                      rem_start;
  logic                      rem_done, rem_done_y;
  logic signed [VALUE_W-1:0] ival_x, ival_y;

  always_comb begin
    mul_ctrl = '0;
    cand_x   = {{(CAND_W - FACT_W - 1){cand_x17[FACT_W]}}, cand_x17};
    cand_y   = {{(CAND_W - FACT_W - 1){delta_ext[FACT_W]}}, delta_ext};
    mplr_x   = code_is_x ? cos_r : sin_r;
    mplr_y   = code_is_x ? sin_r : cos_r;
    if (state_r == S_IDLE) begin
      mul_ctrl.start = in_accept && in_motion;
      mul_ctrl.sgn   = 1'b1;
    end else begin
      // scale pass: rotated Q14 product times unsigned Q8.8 scale
      mul_ctrl.start = (state_r == S_MUL1) && mul_done;
      mul_ctrl.sgn   = 1'b0;
      cand_x         = prod_x[CAND_W-1:0];
      cand_y         = prod_y[CAND_W-1:0];
      mplr_x         = scale_r;
      mplr_y         = scale_r;
    end
  end

  assign rem_start = (state_r == S_MUL2) && mul_done && mul_done_y;

  pmrs_serial_mul u_mul_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mul_ctrl),
    .cand  (cand_x),
    .mplr  (mplr_x),
    .done  (mul_done),
    .prod  (prod_x)
  );

  pmrs_serial_mul u_mul_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mul_ctrl),
    .cand  (cand_y),
    .mplr  (mplr_y),
    .done  (mul_done_y),
    .prod  (prod_y)
  );

  pmrs_remainder u_rem_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .prod  (prod_x),
    .done  (rem_done),
    .ival  (ival_x)
  );

  pmrs_remainder u_rem_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .prod  (prod_y),
    .done  (rem_done_y),
    .ival  (ival_y)
  );

  // pass-through event held until the output register is free
  logic [DATA_W-1:0] pass_r, pass_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;
  logic              nz_x, nz_y;

  assign out_free = !out_valid_r || out_tready;
  assign nz_x     = (ival_x != '0);
  assign nz_y     = (ival_y != '0);

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          pass_nxt  = in_tdata;
          state_nxt = in_motion ? S_MUL1 : S_PASS;
        end
      end
      S_PASS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pass_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (rem_done && rem_done_y) begin
          if (nz_x) begin
            state_nxt = S_EMIT_X;
          end else if (nz_y) begin
            state_nxt = S_EMIT_Y;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT_X: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ival_x, CODE_X, EVT_REL};
          out_last_nxt  = !nz_y;
          state_nxt     = nz_y ? S_EMIT_Y : S_IDLE;
        end
      end
      S_EMIT_Y: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ival_y, CODE_Y, EVT_REL};
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pass_r     <= pass_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
